[hw/rtl/ptmc_pkg.sv]
// Shared types and constants for the pausable tick media clock.
`default_nettype none

package ptmc_pkg;

  // Operation codes carried on the input channel
  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_STOP   = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_SEEK   = 3'd4,
    OP_QUERY  = 3'd5
  } opcode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CHK,
    ST_DIV,
    ST_ADD
  } state_e;

  localparam int unsigned FreqW   = 45;
  localparam int unsigned TickW   = 63;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned ProdW   = TickW + 20;  // elapsed ticks times one million
  localparam int unsigned CntW    = 6;

  localparam logic [19:0]      UsPerSec  = 20'd1000000;
  localparam logic [FreqW-1:0] FreqLimit = 45'd18446744073709;
  localparam logic [FreqW-1:0] FreqReset = 45'd10000000;

  // APB register map: one 64-bit register at byte offset 0
  localparam int unsigned PaddrW   = 4;
  localparam logic        RegFreq  = 1'b0;

endpackage : ptmc_pkg

`default_nettype wire

[hw/rtl/ptmc_if.sv]
// Valid/ready channel interfaces for the command and result beats.
`default_nettype none

interface ptmc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [62:0] tick_count;
  logic signed [63:0] play_time_in;
  logic        start_paused;

  modport source (output valid, opcode, tick_count, play_time_in, start_paused,
                  input ready);
  modport sink   (input valid, opcode, tick_count, play_time_in, start_paused,
                  output ready);
endinterface : ptmc_in_if

interface ptmc_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic signed [63:0] play_time;
  logic        is_active;
  logic        is_paused;

  modport source (output valid, ok, play_time, is_active, is_paused, input ready);
  modport sink   (input valid, ok, play_time, is_active, is_paused, output ready);
endinterface : ptmc_out_if

`default_nettype wire

[hw/rtl/pausable_tick_media_clock.sv]
// Pausable tick media clock: maps a free-running tick counter to media time.
//
// Usage: each command beat on in_i (start, stop, pause, resume, seek, query)
// yields exactly one result beat on out_o with ok, play_time and the clock
// flags after the command. tick_frequency is written over the APB port at
// byte offset 0 (64-bit data, low 45 bits kept); the user must do so only
// while the block is idle, as the block does not enforce this. Start, stop,
// resume, seek, and queries or pauses that need no arithmetic (paused,
// inactive, bad frequency, tick before origin) produce their result in the
// cycle after acceptance. A running query or pause runs in order: the low
// and high halves of elapsed pass one shared 32x20 multiplier to form
// elapsed*1e6, the quotient range is checked, a restoring divider retires
// one quotient bit per cycle for all 63 bits, and the origin is added; a
// quotient out of range ends it at the check. in_i.ready stays low throughout.
// The result sits in an output register; a new command is taken while it
// is being taken by the receiver, and held off while the receiver stalls.
// Reset clears the clock state (inactive, not paused, zero origin) and
// restores tick_frequency to 10000000.
`default_nettype none

module pausable_tick_media_clock
  import ptmc_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  ptmc_in_if.sink            in_i,
  ptmc_out_if.source         out_o,
  input  wire                psel_i,
  input  wire                penable_i,
  input  wire                pwrite_i,
  input  wire [PaddrW-1:0]   paddr_i,
  input  wire [63:0]         pwdata_i,
  output logic [63:0]        prdata_o,
  output logic               pready_o
);

  state_e             state_q, state_d;
  logic               active_q, active_d;
  logic               paused_q, paused_d;
  logic [TickW-1:0]   otick_q, otick_d;
  logic [TimeW-1:0]   omt_q, omt_d;
  logic [FreqW-1:0]   freq_q;
  opcode_e            op_q, op_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [TickW-1:0]   el_q, el_d;
  logic [ProdW-1:0]   acc_q, acc_d;
  logic [FreqW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovld_q, ovld_d;
  logic               ook_q, ook_d;
  logic [TimeW-1:0]   omt_res_q, omt_res_d;
  logic               oact_q, oact_d;
  logic               opau_q, opau_d;

  logic               in_ready;
  logic               freq_ok;
  logic [31:0]        mul_a;
  logic [51:0]        prod;
  logic [FreqW+1:0]   diff;
  logic               qbit;
  logic [TimeW:0]     sum;
  logic               fin;
  logic               res_ok;
  logic [TimeW-1:0]   res_mt;
  logic               go;

  // APB: always ready, one register
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[3] == RegFreq) ? {{(64-FreqW){1'b0}}, freq_q} : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FreqReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o && paddr_i[3] == RegFreq) begin
      freq_q <= pwdata_i[FreqW-1:0];
    end
  end

  assign freq_ok = (freq_q != '0) && (freq_q <= FreqLimit);

  // Shared multiplier: low then high half of the elapsed tick count
  assign mul_a = (state_q == ST_MUL_HI) ? {1'b0, el_q[62:32]} : el_q[31:0];
  assign prod  = {20'd0, mul_a} * {32'd0, UsPerSec};

  // Restoring divide step
  assign diff = {1'b0, rem_q, acc_q[TickW-1]} - {2'b00, freq_q};
  assign qbit = !diff[FreqW+1];

  // Signed origin plus non-negative elapsed microseconds
  assign sum = {omt_q[TimeW-1], omt_q} + {2'b00, acc_q[TickW-1:0]};

  assign in_ready   = (state_q == ST_IDLE) && (!ovld_q || out_o.ready);
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
      paused_q <= 1'b0;
      otick_q  <= '0;
      omt_q    <= '0;
      ovld_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      paused_q <= paused_d;
      otick_q  <= otick_d;
      omt_q    <= omt_d;
      ovld_q   <= ovld_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    tick_q    <= tick_d;
    el_q      <= el_d;
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    ook_q     <= ook_d;
    omt_res_q <= omt_res_d;
    oact_q    <= oact_d;
    opau_q    <= opau_d;
  end

  // Sequencer: next state, clock state and result beat
  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    paused_d  = paused_q;
    otick_d   = otick_q;
    omt_d     = omt_q;
    op_d      = op_q;
    tick_d    = tick_q;
    el_d      = el_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    ovld_d    = ovld_q;
    ook_d     = ook_q;
    omt_res_d = omt_res_q;
    oact_d    = oact_q;
    opau_d    = opau_q;
    fin       = 1'b0;
    res_ok    = 1'b0;
    res_mt    = '0;
    go        = 1'b0;

    // drop the result once taken
    if (ovld_q && out_o.ready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_ready) begin
          op_d   = opcode_e'(in_i.opcode);
          tick_d = in_i.tick_count;
          el_d   = in_i.tick_count - otick_q;
          fin    = 1'b1;
          case (in_i.opcode)
            OP_START: begin
              active_d = 1'b0;
              paused_d = 1'b0;
              otick_d  = '0;
              omt_d    = '0;
              if (freq_ok) begin
                otick_d  = in_i.tick_count;
                omt_d    = in_i.play_time_in;
                active_d = 1'b1;
                paused_d = in_i.start_paused;
                res_ok   = 1'b1;
              end
            end
            OP_STOP: begin
              active_d = 1'b0;
              paused_d = 1'b0;
              otick_d  = '0;
              omt_d    = '0;
              res_ok   = 1'b1;
            end
            OP_PAUSE: begin
              if (active_q) begin
                if (paused_q) begin
                  res_ok = 1'b1;
                end else if (freq_ok && in_i.tick_count >= otick_q) begin
                  go = 1'b1;
                end
              end
            end
            OP_RESUME: begin
              if (active_q) begin
                if (paused_q) begin
                  otick_d  = in_i.tick_count;
                  paused_d = 1'b0;
                end
                res_ok = 1'b1;
              end
            end
            OP_SEEK: begin
              if (active_q) begin
                omt_d   = in_i.play_time_in;
                otick_d = in_i.tick_count;
                res_ok  = 1'b1;
              end
            end
            OP_QUERY: begin
              if (active_q) begin
                if (paused_q) begin
                  res_ok = 1'b1;
                  res_mt = omt_q;
                end else if (freq_ok && in_i.tick_count >= otick_q) begin
                  go = 1'b1;
                end
              end
            end
            default: ;
          endcase
          if (go) begin
            fin     = 1'b0;
            state_d = ST_MUL_LO;
          end
        end
      end
      ST_MUL_LO: begin
        acc_d   = {31'd0, prod};
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        acc_d   = acc_q + {prod[50:0], 32'd0};
        state_d = ST_CHK;
      end
      ST_CHK: begin
        // quotient needs more than 63 bits: overflow
        if ({25'd0, acc_q[ProdW-1:TickW]} >= freq_q) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rem_d   = {25'd0, acc_q[ProdW-1:TickW]};
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = qbit ? diff[FreqW-1:0] : {rem_q[FreqW-2:0], acc_q[TickW-1]};
        acc_d = {acc_q[ProdW-1:TickW], acc_q[TickW-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(TickW - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        fin     = 1'b1;
        state_d = ST_IDLE;
        if (sum[TimeW] == sum[TimeW-1]) begin
          res_ok = 1'b1;
          if (op_q == OP_PAUSE) begin
            omt_d    = sum[TimeW-1:0];
            otick_d  = tick_q;
            paused_d = 1'b1;
          end else begin
            res_mt = sum[TimeW-1:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // load the result beat
    if (fin) begin
      ovld_d    = 1'b1;
      ook_d     = res_ok;
      omt_res_d = res_mt;
      oact_d    = active_d;
      opau_d    = paused_d;
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.ok         = ook_q;
  assign out_o.play_time  = omt_res_q;
  assign out_o.is_active  = oact_q;
  assign out_o.is_paused  = opau_q;

`ifndef SYNTHESIS
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == ST_IDLE)
    else $error("ready raised while sequencer busy");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ok) |-> out_o.play_time == '0)
    else $error("failed result carries nonzero media time");

  a_paused_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    paused_q |-> active_q)
    else $error("clock paused while inactive");

  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> cnt_q < CntW'(TickW))
    else $error("divide step count out of range");
`endif

endmodule : pausable_tick_media_clock

`default_nettype wire

[verif/tb.sv]
// Testbench for the pausable tick media clock: directed cases, then random command traffic.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptmc_pkg::*;

  // Opcodes outside the defined set; the block must reject them
  localparam logic [2:0]        OpSpare6      = 3'd6;
  localparam logic [2:0]        OpSpare7      = 3'd7;
  localparam logic [63:0]       TimeMax       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]       TimeMin       = 64'h8000_0000_0000_0000;
  localparam logic [62:0]       TickMax       = '1;
  localparam logic [63:0]       UsPerSec64    = 64'd1_000_000;
  localparam logic [PaddrW-1:0] FreqAddr      = {RegFreq, 3'b000};
  localparam int unsigned       ResultLatency = 68;
  localparam int unsigned       StallLimit    = 4000;
  localparam int unsigned       ReportCap     = 50;

  typedef struct packed {
    logic        ok;
    logic [63:0] time_us;
    logic        active;
    logic        paused;
  } clk_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  ptmc_in_if  cmd_ch ();
  ptmc_out_if res_ch ();

  pausable_tick_media_clock dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (cmd_ch),
    .out_o     (res_ch),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Predicted clock state and frequency register
  logic [FreqW-1:0] pr_freq;
  logic             pr_active;
  logic             pr_paused;
  logic [62:0]      pr_org_tick;
  logic [63:0]      pr_org_time;

  clk_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned stall_cycles;
  bit          steady;

  function automatic logic freq_ok(input logic [FreqW-1:0] f);
    return (f != '0) && (f <= FreqLimit);
  endfunction

  function automatic void clear_clock();
    pr_active   = 1'b0;
    pr_paused   = 1'b0;
    pr_org_tick = '0;
    pr_org_time = '0;
  endfunction

  // Media time at a given tick; returns 0 when no valid time exists
  function automatic logic media_now(input logic [62:0] tick, output logic [63:0] t_us);
    logic [63:0]  f;
    logic [63:0]  elapsed;
    logic [63:0]  whole;
    logic [63:0]  rem;
    logic [63:0]  whole_us;
    logic [63:0]  frac_us;
    logic [63:0]  el_us;
    logic [127:0] prod;
    t_us = '0;
    if (!pr_active) return 1'b0;
    if (pr_paused) begin
      t_us = pr_org_time;
      return 1'b1;
    end
    if (tick < pr_org_tick || !freq_ok(pr_freq)) return 1'b0;
    f       = 64'(pr_freq);
    elapsed = 64'(tick - pr_org_tick);
    whole   = elapsed / f;
    rem     = elapsed % f;
    if (whole > TimeMax / UsPerSec64) return 1'b0;
    whole_us = whole * UsPerSec64;
    prod     = 128'(rem) * 128'(UsPerSec64);
    frac_us  = 64'(prod / 128'(f));
    if (frac_us > TimeMax - whole_us) return 1'b0;
    el_us = whole_us + frac_us;
    // signed sum overflows when the sign-flipped origin exceeds all-ones minus elapsed
    if ((pr_org_time ^ TimeMin) > ~el_us) return 1'b0;
    t_us = pr_org_time + el_us;
    return 1'b1;
  endfunction

  // Apply one command to the predicted clock and form its result beat
  function automatic clk_result_t advance_clock(input logic [2:0] op, input logic [62:0] tick,
                                                input logic [63:0] t_in, input logic sp);
    clk_result_t r;
    logic [63:0] t;
    r = '0;
    case (op)
      OP_START: begin
        clear_clock();
        if (freq_ok(pr_freq)) begin
          pr_org_tick = tick;
          pr_org_time = t_in;
          pr_active   = 1'b1;
          pr_paused   = sp;
          r.ok        = 1'b1;
        end
      end
      OP_STOP: begin
        clear_clock();
        r.ok = 1'b1;
      end
      OP_PAUSE: begin
        if (pr_active) begin
          if (pr_paused) begin
            r.ok = 1'b1;
          end else if (media_now(tick, t)) begin
            pr_org_time = t;
            pr_org_tick = tick;
            pr_paused   = 1'b1;
            r.ok        = 1'b1;
          end
        end
      end
      OP_RESUME: begin
        if (pr_active) begin
          if (pr_paused) begin
            pr_org_tick = tick;
            pr_paused   = 1'b0;
          end
          r.ok = 1'b1;
        end
      end
      OP_SEEK: begin
        if (pr_active) begin
          pr_org_time = t_in;
          pr_org_tick = tick;
          r.ok        = 1'b1;
        end
      end
      OP_QUERY: begin
        r.ok      = media_now(tick, t);
        r.time_us = t;
      end
      default: ;
    endcase
    r.active = pr_active;
    r.paused = pr_paused;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < ReportCap)
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Check each result beat against the oldest prediction; pace the receiver
  always @(posedge clk_i) begin : check_results
    clk_result_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with no command pending", res_ch.play_time, '0);
        end else begin
          want = pending_results.pop_front();
          if (res_ch.ok !== want.ok)
            report_mismatch("ok", 64'(res_ch.ok), 64'(want.ok));
          if (res_ch.play_time !== want.time_us)
            report_mismatch("play_time", res_ch.play_time, want.time_us);
          if (res_ch.is_active !== want.active)
            report_mismatch("is_active", 64'(res_ch.is_active), 64'(want.active));
          if (res_ch.is_paused !== want.paused)
            report_mismatch("is_paused", 64'(res_ch.is_paused), 64'(want.paused));
        end
      end
      stall_cycles <= ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) ?
                      0 : stall_cycles + 1;
      res_ch.ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  // Abort when no beat moves for too long
  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, StallLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Send one command beat, idling at random beforehand
  task automatic send_cmd(input logic [2:0] op, input logic [62:0] tick,
                          input logic [63:0] t_in, input logic sp);
    while (!steady && $urandom_range(99) < 9) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.opcode        <= op;
    cmd_ch.tick_count    <= tick;
    cmd_ch.play_time_in  <= t_in;
    cmd_ch.start_paused  <= sp;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    pending_results.push_back(advance_clock(op, tick, t_in, sp));
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write tick_frequency while idle, then read it back
  task automatic write_freq(input logic [63:0] value);
    logic [63:0] rd;
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FreqAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pr_freq = value[FreqW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[FreqW-1:0] !== pr_freq)
      report_mismatch("tick_frequency readback", rd, 64'(pr_freq));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Tick near the current origin on a log scale, with some wild values
  function automatic logic [62:0] pick_tick();
    logic [63:0] span;
    case ($urandom_range(19))
      0: return 63'(rand64());
      1: return pr_org_tick - 63'($urandom_range(1000, 1));
      2: return TickMax;
      3: return '0;
      default: begin
        span = rand64() >> $urandom_range(63, 8);
        return pr_org_tick + span[62:0];
      end
    endcase
  endfunction

  function automatic logic [63:0] pick_time();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(15))
      0: return rand64();
      1: return TimeMax;
      2: return TimeMin;
      3: return TimeMax - 64'($urandom_range(100000));
      default: return {{32{w[31]}}, w};
    endcase
  endfunction

  task automatic test_inactive_clock();
    send_cmd(OP_QUERY, TickMax, '0, 1'b0);
    send_cmd(OP_PAUSE, '0, '0, 1'b0);
    send_cmd(OP_RESUME, 63'd77, '0, 1'b1);
    send_cmd(OP_SEEK, 63'd5, TimeMin, 1'b0);
    send_cmd(OpSpare6, 63'd9, TimeMax, 1'b1);
  endtask

  task automatic test_running_clock();
    send_cmd(OP_START, 63'd1000, '0, 1'b0);
    send_cmd(OP_QUERY, 63'd11000, '0, 1'b0);
    // tick before the origin
    send_cmd(OP_QUERY, 63'd999, '0, 1'b0);
    send_cmd(OP_PAUSE, 63'd20000, '0, 1'b0);
    send_cmd(OP_PAUSE, 63'd30000, '0, 1'b0);
    send_cmd(OP_RESUME, 63'd5, '0, 1'b0);
    send_cmd(OP_RESUME, 63'd50, '0, 1'b0);
    send_cmd(OP_SEEK, 63'd100, -64'sd5, 1'b0);
    send_cmd(OP_QUERY, TickMax, '0, 1'b0);
    send_cmd(OP_STOP, 63'd3, TimeMax, 1'b1);
  endtask

  task automatic test_start_paused();
    send_cmd(OP_START, TickMax, TimeMin, 1'b1);
    send_cmd(OP_QUERY, '0, '0, 1'b0);
  endtask

  task automatic test_overflow();
    // fractional part pushes the scaled time past the signed maximum
    write_freq(64'd10);
    send_cmd(OP_START, '0, '0, 1'b0);
    send_cmd(OP_QUERY, 63'd92233720368549, '0, 1'b0);
    send_cmd(OP_QUERY, TickMax, '0, 1'b0);
    // origin plus elapsed lands exactly on, then past, the signed maximum
    write_freq(64'd1_000_000);
    send_cmd(OP_START, '0, TimeMax - 64'd5, 1'b0);
    send_cmd(OP_QUERY, 63'd5, '0, 1'b0);
    send_cmd(OP_PAUSE, 63'd6, '0, 1'b0);
  endtask

  task automatic test_bad_frequency();
    write_freq('0);
    send_cmd(OP_START, 63'd8, 64'd8, 1'b0);
    write_freq(64'(FreqLimit));
    send_cmd(OP_START, '0, '0, 1'b0);
    send_cmd(OP_QUERY, TickMax, '0, 1'b0);
    // frequency goes bad under a running clock
    write_freq('0);
    send_cmd(OP_QUERY, 63'd10, '0, 1'b0);
  endtask

  // Mostly well-formed sessions: restart soon after a stop, then queries and edits
  task automatic random_burst(input int unsigned count);
    int unsigned r;
    logic [2:0]  op;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (!pr_active && r < 60) op = OP_START;
      else if (r < 8)  op = OP_START;
      else if (r < 11) op = OP_STOP;
      else if (r < 23) op = OP_PAUSE;
      else if (r < 35) op = OP_RESUME;
      else if (r < 42) op = OP_SEEK;
      else if (r < 97) op = OP_QUERY;
      else op = r[0] ? OpSpare6 : OpSpare7;
      if ($urandom_range(59) == 0) drain();
      send_cmd(op, pick_tick(), pick_time(), 1'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    logic [FreqW-1:0] plan[8];
    plan[0] = 45'd48000;
    plan[1] = 45'd1;
    plan[2] = FreqLimit;
    plan[3] = 45'(64'd1 + rand64() % 64'(FreqLimit));
    plan[4] = FreqReset;
    plan[5] = '0;
    plan[6] = {2'b11, 43'(rand64())};
    plan[7] = 45'd90000;
    for (int i = 0; i < 8; i++) begin
      // last phase runs with no idling on either side
      write_freq({19'($urandom), plan[i]});
      steady = (i == 7);
      random_burst((i == 5 || i == 6) ? 100 : 260);
    end
    drain();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.opcode        <= OP_QUERY;
    cmd_ch.tick_count    <= '0;
    cmd_ch.play_time_in  <= '0;
    cmd_ch.start_paused  <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    steady       = 1'b0;
    mismatches   = 0;
    pr_freq      = FreqReset;
    clear_clock();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_inactive_clock();
    test_running_clock();
    test_start_paused();
    test_overflow();
    test_bad_frequency();
    test_random_traffic();

    drain();
    repeat (ResultLatency + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule : tb

`default_nettype wire
